// ===== rtl/y2nv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2nv_pkg
// shared types and constants of the yuy2 to nv12 converter
// ----------------------------------------------------------------------------
package y2nv_pkg;

	// widest source line the chroma line store covers, in pixels
	localparam int MAX_WIDTH  = 4096;
	localparam int HALF_PAIRS = MAX_WIDTH / 2;
	localparam int PAIR_AW    = $clog2(HALF_PAIRS);
	localparam int STORE_AW   = PAIR_AW + 1;
	localparam int STORE_DEPTH = 2 * HALF_PAIRS;
	localparam int CHROMA_W   = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_MARGIN_LEFT   = 3'd2,
		REG_MARGIN_TOP    = 3'd3,
		REG_MARGIN_RIGHT  = 3'd4,
		REG_MARGIN_BOTTOM = 3'd5,
		REG_INTERLACED    = 3'd6
	} reg_index_t;

	localparam logic [12:0] FRAME_WIDTH_RST  = 13'd1920;
	localparam logic [12:0] FRAME_HEIGHT_RST = 13'd1080;

	typedef struct packed {
		logic [12:0] frame_width;
		logic [12:0] frame_height;
		logic [11:0] margin_left;
		logic [11:0] margin_top;
		logic [11:0] margin_right;
		logic [11:0] margin_bottom;
		logic        interlaced_mode;
	} cfg_t;

	// how the chroma of an item combines with the stored row
	typedef enum logic [1:0] {
		OP_NONE,
		OP_AVG,
		OP_PREV3,
		OP_CUR3
	} chroma_op_t;

	typedef struct packed {
		logic [7:0]  luma_even;
		logic [7:0]  luma_odd;
		logic [7:0]  chroma_blue;
		logic [7:0]  chroma_red;
		logic [11:0] row;
		logic [10:0] pair;
		logic [11:0] chroma_row;
		chroma_op_t  op;
	} item_t;

	typedef struct packed {
		logic                we;
		logic                re;
		logic [STORE_AW-1:0] addr;
		logic [CHROMA_W-1:0] wdata;
	} ram_req_t;

endpackage

// ===== rtl/y2nv_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2nv_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module y2nv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== rtl/y2nv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2nv_front
// raster position, crop window and line store access; holds the s1 item
// ----------------------------------------------------------------------------
module y2nv_front (
	input  logic              clk,
	input  logic              arst_n,
	input  y2nv_pkg::cfg_t    cfg,
	input  logic              accept,
	input  logic              frame_start,
	input  logic [7:0]        luma_even,
	input  logic [7:0]        chroma_blue,
	input  logic [7:0]        luma_odd,
	input  logic [7:0]        chroma_red,
	input  logic              pop,
	output logic              valid_s1,
	output y2nv_pkg::item_t   item_s1,
	output y2nv_pkg::ram_req_t ram_req
);
	import y2nv_pkg::*;

	logic [11:0] col_q, row_q;
	logic [11:0] col_cur, row_cur;
	logic [11:0] wpl_raw, wpl;
	logic [10:0] left_half, right_half;
	logic        keep_col, keep_row, keep;
	logic [11:0] pair, r;
	logic        in_store, group_full;
	logic        line_end, frame_end;
	logic        bank;
	logic        wr_req, rd_req;
	item_t       item_d;

	always_comb begin
		col_cur    = frame_start ? 12'd0 : col_q;
		row_cur    = frame_start ? 12'd0 : row_q;
		wpl_raw    = cfg.frame_width[12:1];
		wpl        = (wpl_raw == 12'd0) ? 12'd1 : wpl_raw;
		left_half  = cfg.margin_left[11:1];
		right_half = cfg.margin_right[11:1];

		keep_col = (col_cur >= {1'b0, left_half})
			&& (({1'b0, col_cur} + {2'b0, right_half}) < {1'b0, wpl});
		keep_row = (row_cur >= cfg.margin_top)
			&& (({1'b0, row_cur} + {1'b0, cfg.margin_bottom}) < cfg.frame_height);
		keep     = keep_col && keep_row;

		pair     = col_cur - {1'b0, left_half};
		r        = row_cur - cfg.margin_top;
		in_store = (32'(pair) < HALF_PAIRS);
		// last row of this group of four still inside the window
		group_full = ({2'b0, r[11:2], 2'b11} + {2'b0, cfg.margin_top}
			+ {2'b0, cfg.margin_bottom}) < {1'b0, cfg.frame_height};

		wr_req = 1'b0;
		rd_req = 1'b0;
		bank   = 1'b0;
		item_d.op = OP_NONE;
		if (in_store) begin
			if (!cfg.interlaced_mode) begin
				if (!r[0]) begin
					wr_req = 1'b1;
				end else begin
					rd_req    = 1'b1;
					item_d.op = OP_AVG;
				end
			end else begin
				bank = r[0];
				if (!r[1]) begin
					wr_req = 1'b1;
				end else if (group_full) begin
					rd_req    = 1'b1;
					item_d.op = r[0] ? OP_CUR3 : OP_PREV3;
				end
			end
		end

		item_d.luma_even   = luma_even;
		item_d.luma_odd    = luma_odd;
		item_d.chroma_blue = chroma_blue;
		item_d.chroma_red  = chroma_red;
		item_d.row         = r;
		item_d.pair        = pair[10:0];
		item_d.chroma_row  = cfg.interlaced_mode ? {1'b0, r[11:2], r[0]}
			: {1'b0, r[11:1]};

		ram_req.we    = accept && keep && wr_req;
		ram_req.re    = accept && keep && rd_req;
		ram_req.addr  = {bank, pair[PAIR_AW-1:0]};
		ram_req.wdata = {chroma_blue, chroma_red};

		line_end  = ({1'b0, col_cur} + 13'd1) >= {1'b0, wpl};
		frame_end = (row_cur == 12'hfff)
			|| (({1'b0, row_cur} + 13'd1) >= cfg.frame_height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (line_end) begin
				col_q <= '0;
				row_q <= frame_end ? 12'd0 : row_cur + 12'd1;
			end else begin
				col_q <= col_cur + 12'd1;
				row_q <= row_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (pop) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ===== rtl/y2nv_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2nv_emit
// vertical chroma filter and result sequencer into the output register
// ----------------------------------------------------------------------------
module y2nv_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_s1,
	input  y2nv_pkg::item_t                   item_s1,
	input  logic [y2nv_pkg::CHROMA_W-1:0]     stored,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              plane,
	output logic [11:0]                       out_row,
	output logic [10:0]                       out_pair,
	output logic [7:0]                        first_byte,
	output logic [7:0]                        second_byte,
	output logic                              last
);
	import y2nv_pkg::*;

	function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b} + 9'd1;
		return s[8:1];
	endfunction

	// (3*a + b + 2) >> 2
	function automatic logic [7:0] wgt31(input logic [7:0] a, input logic [7:0] b);
		logic [9:0] s;
		s = {2'b0, a} + {1'b0, a, 1'b0} + {2'b0, b} + 10'd2;
		return s[9:2];
	endfunction

	logic       luma_done_q;
	logic       has_chroma;
	logic       load;
	logic [7:0] su, sv, cu, cv;

	always_comb begin
		su = stored[15:8];
		sv = stored[7:0];
		case (item_s1.op)
			OP_AVG: begin
				cu = avg2(su, item_s1.chroma_blue);
				cv = avg2(sv, item_s1.chroma_red);
			end
			OP_PREV3: begin
				cu = wgt31(su, item_s1.chroma_blue);
				cv = wgt31(sv, item_s1.chroma_red);
			end
			OP_CUR3: begin
				cu = wgt31(item_s1.chroma_blue, su);
				cv = wgt31(item_s1.chroma_red, sv);
			end
			default: begin
				cu = '0;
				cv = '0;
			end
		endcase
		has_chroma = (item_s1.op != OP_NONE);
		load       = !out_valid || out_ready;
		pop        = valid_s1 && load && (luma_done_q || !has_chroma);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid   <= 1'b0;
			luma_done_q <= 1'b0;
		end else if (load) begin
			out_valid <= valid_s1;
			if (valid_s1) begin
				luma_done_q <= !luma_done_q && has_chroma;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && valid_s1) begin
			out_pair <= item_s1.pair;
			if (!luma_done_q) begin
				plane       <= 1'b0;
				out_row     <= item_s1.row;
				first_byte  <= item_s1.luma_even;
				second_byte <= item_s1.luma_odd;
				last        <= !has_chroma;
			end else begin
				plane       <= 1'b1;
				out_row     <= item_s1.chroma_row;
				first_byte  <= cu;
				second_byte <= cv;
				last        <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/yuy2_to_nv12_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuy2_to_nv12_converter
// crops a yuy2 raster stream and splits it into nv12 luma and chroma results
// ----------------------------------------------------------------------------
// usage:
//  input channel in_valid/in_ready carries one yuy2 word (y0 u y1 v) per item,
//  frame_start on the first word of a frame. words outside the crop window
//  are consumed and dropped.
//  output channel out_valid/out_ready carries results: a luma pair for every
//  kept word, followed by a chroma pair (u,v) when the word closes a row pair
//  (progressive) or the third/fourth row of a four row group (interlaced).
//  last marks the final result of a word.
//  a word is taken into the s1 register and its luma result then into the
//  output register; a chroma result is loaded into the output register as
//  its luma result leaves it.
//  throughput: one word per cycle while only luma comes out and out_ready is
//  high; a word with a chroma result keeps the s1 stage until its chroma loads.
//  the single port chroma line store is read or written at most once per word.
//  reset clears position, pipeline and registers to defaults; line store
//  contents stay undefined and need no clearing pass.
//  a stalled receiver backs up through the output register and the s1 stage
//  to in_ready; nothing is lost. configure only while idle.
// ----------------------------------------------------------------------------
module yuy2_to_nv12_converter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [y2nv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [y2nv_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              frame_start,
	input  logic [7:0]                        luma_even,
	input  logic [7:0]                        chroma_blue,
	input  logic [7:0]                        luma_odd,
	input  logic [7:0]                        chroma_red,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              plane,
	output logic [11:0]                       out_row,
	output logic [10:0]                       out_pair,
	output logic [7:0]                        first_byte,
	output logic [7:0]                        second_byte,
	output logic                              last
);
	import y2nv_pkg::*;

	cfg_t          cfg_q;
	logic          accept;
	logic          pop;
	logic          valid_s1;
	item_t         item_s1;
	ram_req_t      ram_req;
	logic [CHROMA_W-1:0] stored;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width     <= FRAME_WIDTH_RST;
			cfg_q.frame_height    <= FRAME_HEIGHT_RST;
			cfg_q.margin_left     <= '0;
			cfg_q.margin_top      <= '0;
			cfg_q.margin_right    <= '0;
			cfg_q.margin_bottom   <= '0;
			cfg_q.interlaced_mode <= 1'b0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_FRAME_WIDTH:   cfg_q.frame_width     <= cfg_data;
				REG_FRAME_HEIGHT:  cfg_q.frame_height    <= cfg_data;
				REG_MARGIN_LEFT:   cfg_q.margin_left     <= cfg_data[11:0];
				REG_MARGIN_TOP:    cfg_q.margin_top      <= cfg_data[11:0];
				REG_MARGIN_RIGHT:  cfg_q.margin_right    <= cfg_data[11:0];
				REG_MARGIN_BOTTOM: cfg_q.margin_bottom   <= cfg_data[11:0];
				REG_INTERLACED:    cfg_q.interlaced_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign in_ready = !valid_s1 || pop;
	assign accept   = in_valid && in_ready;

	y2nv_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.accept      (accept),
		.frame_start (frame_start),
		.luma_even   (luma_even),
		.chroma_blue (chroma_blue),
		.luma_odd    (luma_odd),
		.chroma_red  (chroma_red),
		.pop         (pop),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.ram_req     (ram_req)
	);

	y2nv_ram #(
		.WIDTH (CHROMA_W),
		.DEPTH (STORE_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_req.we),
		.re    (ram_req.re),
		.addr  (ram_req.addr),
		.wdata (ram_req.wdata),
		.rdata (stored)
	);

	y2nv_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.stored      (stored),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.plane       (plane),
		.out_row     (out_row),
		.out_pair    (out_pair),
		.first_byte  (first_byte),
		.second_byte (second_byte),
		.last        (last)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the yuy2 to nv12 converter: a directed table of
// words (reset defaults, extreme bytes, pair averaging, interlaced field
// weighting, incomplete groups, empty crop windows) and then many register
// settings with random pixel content. Every accepted word runs through a local
// nv12 predictor and each result is compared in order, with random sender
// bursts and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
	import y2nv_pkg::*;

	localparam int SETTLE_CYCLES  = 4;
	localparam int END_CYCLES     = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEM_TARGET    = 1000;
	localparam int PRINT_LIMIT    = 20;

	typedef struct packed {
		logic       fs;
		logic [7:0] y0;
		logic [7:0] u;
		logic [7:0] y1;
		logic [7:0] v;
	} yuy2_t;

	typedef struct packed {
		logic        plane;
		logic [11:0] row;
		logic [10:0] pair;
		logic [7:0]  first;
		logic [7:0]  second;
		logic        last;
	} nv12_t;

	typedef enum logic [1:0] {STEP_REG, STEP_WORD, STEP_TYPED} step_kind_t;
	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PATTERN} rx_mode_t;

	// one directed row: a register write, a predicted word, or a word whose
	// results are written out by hand (n of them, luma then chroma)
	typedef struct {
		step_kind_t kind;
		reg_index_t idx;
		int         data;
		int         fs, y0, u, y1, v;
		int         n, row, pair, crow, cu, cv;
	} step_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  frame_start = 1'b0;
	logic [7:0]            luma_even = '0;
	logic [7:0]            chroma_blue = '0;
	logic [7:0]            luma_odd = '0;
	logic [7:0]            chroma_red = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b1;
	logic                  plane;
	logic [11:0]           out_row;
	logic [10:0]           out_pair;
	logic [7:0]            first_byte;
	logic [7:0]            second_byte;
	logic                  last;

	yuy2_to_nv12_converter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.frame_start (frame_start),
		.luma_even   (luma_even),
		.chroma_blue (chroma_blue),
		.luma_odd    (luma_odd),
		.chroma_red  (chroma_red),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.plane       (plane),
		.out_row     (out_row),
		.out_pair    (out_pair),
		.first_byte  (first_byte),
		.second_byte (second_byte),
		.last        (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state: register copy, chroma rows, raster position
	cfg_t          shadow;
	logic [15:0]   chroma_mem [0:STORE_DEPTH-1];
	int unsigned   col_pos;
	int unsigned   row_pos;

	nv12_t         nv12_due [$];
	int            error_count = 0;
	int            words_sent = 0;
	int            words_kept = 0;
	int            results_checked = 0;
	int            settings_used = 0;
	int            idle_cycles = 0;
	bit            gapless = 1'b0;
	int            burst_left = 8;

	rx_mode_t      rx_mode = RX_OPEN;
	int            rx_left = 0;
	logic [7:0]    rx_tick = '0;

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("[%0t] error: %s", $time, msg);
	endtask

	// nv12 results of one yuy2 word, advancing the raster position
	function automatic void convert_word(input yuy2_t w, output nv12_t res [2], output int n);
		int         wpl, left, right_end, top, bottom_end, col, row;
		int         pair, r, h, ph, su, sv, cu, cv, crow, u, v;
		logic [15:0] s;
		chroma_op_t op;
		n = 0;
		res[0] = '0;
		res[1] = '0;
		if (w.fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		u = w.u;
		v = w.v;
		wpl = int'(shadow.frame_width) >> 1;
		if (wpl == 0)
			wpl = 1;
		left = int'(shadow.margin_left) >> 1;
		right_end = wpl - (int'(shadow.margin_right) >> 1);
		top = int'(shadow.margin_top);
		bottom_end = int'(shadow.frame_height) - int'(shadow.margin_bottom);
		col = int'(col_pos);
		row = int'(row_pos);

		if (col >= left && col < right_end && row >= top && row < bottom_end) begin
			pair = col - left;
			r = row - top;
			h = bottom_end - top;
			op = OP_NONE;
			res[0] = '{1'b0, 12'(r), 11'(pair), w.y0, w.y1, 1'b1};
			n = 1;
			if (pair < HALF_PAIRS) begin
				if (!shadow.interlaced_mode) begin
					if (r[0] == 1'b0)
						chroma_mem[pair] = {w.u, w.v};
					else begin
						s = chroma_mem[pair];
						op = OP_AVG;
						crow = r >> 1;
					end
				end else begin
					ph = r & 3;
					if (ph < 2)
						chroma_mem[ph * HALF_PAIRS + pair] = {w.u, w.v};
					else if ((r | 3) < h) begin
						s = chroma_mem[(ph & 1) * HALF_PAIRS + pair];
						op = (ph == 2) ? OP_PREV3 : OP_CUR3;
						crow = ((r >> 2) << 1) | (r & 1);
					end
				end
			end
			if (op != OP_NONE) begin
				su = s[15:8];
				sv = s[7:0];
				case (op)
					OP_AVG: begin
						cu = (su + u + 1) >> 1;
						cv = (sv + v + 1) >> 1;
					end
					OP_PREV3: begin
						cu = (3 * su + u + 2) >> 2;
						cv = (3 * sv + v + 2) >> 2;
					end
					default: begin
						cu = (su + 3 * u + 2) >> 2;
						cv = (sv + 3 * v + 2) >> 2;
					end
				endcase
				res[0].last = 1'b0;
				res[1] = '{1'b1, 12'(crow), 11'(pair), 8'(cu), 8'(cv), 1'b1};
				n = 2;
			end
		end

		if (col + 1 >= wpl) begin
			col_pos = 0;
			if (row_pos >= 4095 || row + 1 >= int'(shadow.frame_height))
				row_pos = 0;
			else
				row_pos = row_pos + 1;
		end else begin
			col_pos = (col_pos + 1) & 12'hFFF;
		end
	endfunction

	task automatic write_reg(input reg_index_t idx, input logic [12:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		case (idx)
			REG_FRAME_WIDTH:   shadow.frame_width = d;
			REG_FRAME_HEIGHT:  shadow.frame_height = d;
			REG_MARGIN_LEFT:   shadow.margin_left = d[11:0];
			REG_MARGIN_TOP:    shadow.margin_top = d[11:0];
			REG_MARGIN_RIGHT:  shadow.margin_right = d[11:0];
			REG_MARGIN_BOTTOM: shadow.margin_bottom = d[11:0];
			REG_INTERLACED:    shadow.interlaced_mode = d[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// sender stops, all due results drain, then the pipeline settles
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (nv12_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic pace();
		if (gapless)
			return;
		if (burst_left > 0)
			burst_left--;
		else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
	endtask

	task automatic send_word(input yuy2_t w, input bit predict, output int n);
		nv12_t res [2];
		in_valid    <= 1'b1;
		frame_start <= w.fs;
		luma_even   <= w.y0;
		chroma_blue <= w.u;
		luma_odd    <= w.y1;
		chroma_red  <= w.v;
		do @(posedge clk); while (!in_ready);
		convert_word(w, res, n);
		if (predict)
			for (int k = 0; k < n; k++)
				nv12_due.push_back(res[k]);
		words_sent++;
		if (n > 0)
			words_kept++;
	endtask

	task automatic run_phase(input cfg_t c, input int words, input bit noisy);
		yuy2_t w;
		int    n;
		int    press_at;
		wait_idle();
		write_reg(REG_FRAME_WIDTH, c.frame_width);
		write_reg(REG_FRAME_HEIGHT, c.frame_height);
		write_reg(REG_MARGIN_LEFT, 13'(c.margin_left));
		write_reg(REG_MARGIN_TOP, 13'(c.margin_top));
		write_reg(REG_MARGIN_RIGHT, 13'(c.margin_right));
		write_reg(REG_MARGIN_BOTTOM, 13'(c.margin_bottom));
		write_reg(REG_INTERLACED, 13'(c.interlaced_mode));
		cfg_we <= 1'b0;
		settings_used++;
		gapless = ($urandom_range(0, 3) == 0);
		burst_left = $urandom_range(1, 24);
		press_at = noisy ? $urandom_range(0, words - 1) : -1;
		for (int i = 0; i < words; i++) begin
			// a stray frame start now and then breaks the raster
			w.fs = (i == 0) || (noisy && $urandom_range(0, 99) == 0);
			w.y0 = 8'($urandom);
			w.u  = 8'($urandom);
			w.y1 = 8'($urandom);
			w.v  = 8'($urandom);
			pace();
			send_word(w, 1'b1, n);
			if (i == press_at)
				wait_idle();
		end
	endtask

	// receiver: ready pattern switches at random among always ready, random, sparse and a repeating pattern
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(16, 256);
		end else begin
			rx_left <= rx_left - 1;
		end
		rx_tick <= rx_tick + 1'b1;
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default:   out_ready <= rx_tick[1];
		endcase
	end

	always @(posedge clk) begin : check_out
		nv12_t got;
		nv12_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{plane, out_row, out_pair, first_byte, second_byte, last};
			if (nv12_due.size() == 0) begin
				report_error($sformatf("result with nothing due: plane %0d row %0d pair %0d",
					plane, out_row, out_pair));
			end else begin
				want = nv12_due.pop_front();
				if (got.plane !== want.plane || got.row !== want.row ||
						got.pair !== want.pair || got.first !== want.first ||
						got.second !== want.second || got.last !== want.last)
					report_error($sformatf({"result %0d: got plane %0d row %0d pair %0d ",
						"bytes %02h %02h last %0d, want plane %0d row %0d pair %0d ",
						"bytes %02h %02h last %0d"}, results_checked,
						got.plane, got.row, got.pair, got.first, got.second, got.last,
						want.plane, want.row, want.pair, want.first, want.second, want.last));
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		step_t steps [24];
		yuy2_t w;
		cfg_t  c;
		int    n;
		int    wpl;
		int    h;
		int    words;

		// reset defaults are 1920x1080 progressive; later rows use a 4x4 frame,
		// then a 2x6 interlaced frame (last two rows an incomplete group),
		// then a left crop that leaves nothing
		steps = '{
			'{STEP_TYPED, REG_FRAME_WIDTH, 0, 1, 'h00, 'h00, 'hFF, 'hFF, 1, 0, 0, 0, 0, 0},
			'{STEP_TYPED, REG_FRAME_WIDTH, 0, 0, 'hFF, 'hFF, 'h00, 'h00, 1, 0, 1, 0, 0, 0},
			'{STEP_REG, REG_FRAME_WIDTH, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{STEP_REG, REG_FRAME_HEIGHT, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{STEP_TYPED, REG_FRAME_WIDTH, 0, 1, 'h00, 'h00, 'hFF, 'hFF, 1, 0, 0, 0, 0, 0},
			'{STEP_TYPED, REG_FRAME_WIDTH, 0, 0, 'hFF, 'hFF, 'h00, 'hFF, 1, 0, 1, 0, 0, 0},
			'{STEP_TYPED, REG_FRAME_WIDTH, 0, 0, 'h12, 'hFF, 'h34, 'h00, 2, 1, 0, 0, 'h80, 'h80},
			'{STEP_TYPED, REG_FRAME_WIDTH, 0, 0, 'h56, 'hFF, 'h78, 'hFF, 2, 1, 1, 0, 'hFF, 'hFF},
			'{STEP_WORD, REG_FRAME_WIDTH, 0, 0, 'hA5, 'h3C, 'h5A, 'hC3, 0, 0, 0, 0, 0, 0},
			'{STEP_WORD, REG_FRAME_WIDTH, 0, 0, 'h01, 'h80, 'hFE, 'h7F, 0, 0, 0, 0, 0, 0},
			'{STEP_WORD, REG_FRAME_WIDTH, 0, 0, 'hC3, 'h01, 'h3C, 'hFE, 0, 0, 0, 0, 0, 0},
			'{STEP_WORD, REG_FRAME_WIDTH, 0, 0, 'h7E, 'h81, 'hE7, 'h18, 0, 0, 0, 0, 0, 0},
			'{STEP_REG, REG_INTERLACED, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{STEP_REG, REG_FRAME_WIDTH, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{STEP_REG, REG_FRAME_HEIGHT, 6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{STEP_WORD, REG_FRAME_WIDTH, 0, 1, 'h10, 'hFF, 'h20, 'h00, 0, 0, 0, 0, 0, 0},
			'{STEP_WORD, REG_FRAME_WIDTH, 0, 0, 'h30, 'h00, 'h40, 'hFF, 0, 0, 0, 0, 0, 0},
			'{STEP_WORD, REG_FRAME_WIDTH, 0, 0, 'h50, 'h01, 'h60, 'hFE, 0, 0, 0, 0, 0, 0},
			'{STEP_WORD, REG_FRAME_WIDTH, 0, 0, 'h70, 'hFE, 'h80, 'h01, 0, 0, 0, 0, 0, 0},
			'{STEP_WORD, REG_FRAME_WIDTH, 0, 0, 'h90, 'h55, 'hA0, 'hAA, 0, 0, 0, 0, 0, 0},
			'{STEP_WORD, REG_FRAME_WIDTH, 0, 0, 'hB0, 'hAA, 'hC0, 'h55, 0, 0, 0, 0, 0, 0},
			'{STEP_REG, REG_MARGIN_LEFT, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{STEP_TYPED, REG_FRAME_WIDTH, 0, 1, 'hFF, 'h00, 'hFF, 'h00, 0, 0, 0, 0, 0, 0},
			'{STEP_TYPED, REG_FRAME_WIDTH, 0, 0, 'h00, 'hFF, 'h00, 'hFF, 0, 0, 0, 0, 0, 0}
		};

		shadow = '{FRAME_WIDTH_RST, FRAME_HEIGHT_RST, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0};
		foreach (chroma_mem[i])
			chroma_mem[i] = '0;
		col_pos = 0;
		row_pos = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].kind == STEP_REG) begin
				wait_idle();
				write_reg(steps[i].idx, 13'(steps[i].data));
				cfg_we <= 1'b0;
			end else begin
				w.fs = steps[i].fs[0];
				w.y0 = steps[i].y0[7:0];
				w.u  = steps[i].u[7:0];
				w.y1 = steps[i].y1[7:0];
				w.v  = steps[i].v[7:0];
				pace();
				send_word(w, steps[i].kind == STEP_WORD, n);
				if (steps[i].kind == STEP_TYPED) begin
					if (steps[i].n >= 1)
						nv12_due.push_back(nv12_t'{1'b0, 12'(steps[i].row),
							11'(steps[i].pair), w.y0, w.y1, steps[i].n == 1});
					if (steps[i].n == 2)
						nv12_due.push_back(nv12_t'{1'b1, 12'(steps[i].crow),
							11'(steps[i].pair), 8'(steps[i].cu), 8'(steps[i].cv), 1'b1});
				end
			end
		end

		// large settings: the start of the widest store line, then a frame of
		// one pair per line with a tall height
		c = '{13'd4096, 13'd4096, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0};
		run_phase(c, 200, 1'b0);
		c = '{13'd0, 13'd8191, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0};
		run_phase(c, 64, 1'b0);

		while (words_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 7))
				0: c.frame_width = 13'($urandom_range(0, 3));
				1: c.frame_width = 13'(2 * $urandom_range(1, 8) + 1);
				default: c.frame_width = 13'(2 * $urandom_range(1, 8));
			endcase
			c.margin_left   = ($urandom_range(0, 2) == 0) ? 12'($urandom_range(0, 5)) : 12'd0;
			c.margin_right  = ($urandom_range(0, 2) == 0) ? 12'($urandom_range(0, 5)) : 12'd0;
			c.margin_top    = ($urandom_range(0, 2) == 0) ? 12'($urandom_range(0, 3)) : 12'd0;
			c.margin_bottom = ($urandom_range(0, 2) == 0) ? 12'($urandom_range(0, 3)) : 12'd0;
			c.interlaced_mode = 1'($urandom_range(0, 1));
			h = c.interlaced_mode ? 4 * $urandom_range(1, 3) : 2 * $urandom_range(1, 6);
			if ($urandom_range(0, 3) == 0)
				h = $urandom_range(1, 12);
			c.frame_height = 13'(h + int'(c.margin_top) + int'(c.margin_bottom));
			// now and then a crop that leaves an empty window
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0: c.margin_left = 12'd4094;
					1: c.margin_right = 12'd4094;
					2: c.margin_top = 12'd4094;
					default: c.margin_bottom = 12'd4094;
				endcase
			end
			wpl = int'(c.frame_width) >> 1;
			if (wpl == 0)
				wpl = 1;
			words = wpl * int'(c.frame_height) * $urandom_range(1, 3) +
				$urandom_range(0, 2 * wpl);
			if (words > ITEM_TARGET - words_sent)
				words = ITEM_TARGET - words_sent;
			run_phase(c, words, 1'b1);
		end

		wait_idle();
		repeat (END_CYCLES) @(posedge clk);
		if (nv12_due.size() != 0)
			report_error($sformatf("%0d results never arrived", nv12_due.size()));
		$display("covered %0d words (%0d inside the crop window) over %0d register settings",
			words_sent, words_kept, settings_used);
		$display("checked %0d luma and chroma results, %0d mismatches",
			results_checked, error_count);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/y2nv_pkg.sv
rtl/y2nv_ram.sv
rtl/y2nv_front.sv
rtl/y2nv_emit.sv
rtl/yuy2_to_nv12_converter.sv
tb/testbench.sv
